/* rtl/core/lres_pkg.sv */
// Package for the LED ring effect sequencer: mode, pixel-operation and
// register-index codes, colour and timing constants, and the trail fade.
// Used by every module under rtl/core; depends on nothing.
package lres_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_TRIG = 2'd1,
    MODE_SUCC = 2'd2,
    MODE_WARN = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_WARN = 2'd1,
    CMD_FAIL = 2'd2
  } cmd_t;

  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BREATHE_MIN  = 3'd0,
    CFG_BREATHE_MAX  = 3'd1,
    CFG_BREATHE_STEP = 3'd2,
    CFG_TRIGGER_HOLD = 3'd3,
    CFG_WARNING_HOLD = 3'd4,
    CFG_SUCCESS_HALF = 3'd5,
    CFG_WARNING_HALF = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PIX_HOLD      = 2'd0,
    PIX_FILL      = 2'd1,
    PIX_MARQUEE   = 2'd2,
    PIX_ALTERNATE = 2'd3
  } pix_op_t;

  typedef struct packed {
    pix_op_t     op;
    logic [23:0] colour;
  } pix_cmd_t;

  localparam int DEFAULT_PIXELS = 8;

  localparam logic [23:0] COL_BLACK = 24'h000000;
  localparam logic [23:0] COL_IDLE  = 24'hB0E0E6;
  localparam logic [23:0] COL_TRIG  = 24'hFFA500;
  localparam logic [23:0] COL_SUCC  = 24'h008000;
  localparam logic [23:0] COL_WARN  = 24'hFF0000;

  localparam logic [11:0] RAMP_SPAN  = 12'd3000;
  localparam logic [7:0]  RAMP_START = 8'd150;
  // floor(x * 110 / 3000) == (x * RAMP_RECIP) >> RAMP_SHIFT for x <= 3000
  localparam logic [31:0] RAMP_RECIP = 32'd615175;
  localparam int          RAMP_SHIFT = 24;

  localparam logic [7:0] FADE_SCALE   = 8'd156;
  localparam logic [7:0] TRIG_BRIGHT  = 8'd150;
  localparam logic [7:0] FLASH_BRIGHT = 8'd200;

  localparam logic [7:0]  RST_BREATHE_MIN  = 8'd2;
  localparam logic [7:0]  RST_BREATHE_MAX  = 8'd25;
  localparam logic [15:0] RST_BREATHE_STEP = 16'd30;
  localparam logic [15:0] RST_TRIGGER_HOLD = 16'd3000;
  localparam logic [15:0] RST_WARNING_HOLD = 16'd2000;
  localparam logic [15:0] RST_SUCCESS_HALF = 16'd200;
  localparam logic [15:0] RST_WARNING_HALF = 16'd100;
  localparam logic [7:0]  RST_BREATHE_LVL  = 8'd10;
  localparam logic [7:0]  RST_BRIGHTNESS   = 8'd50;

  function automatic logic [7:0] fade_channel(input logic [7:0] c);
    logic [15:0] p;
    p = 16'(c) * 16'(FADE_SCALE);
    return p[15:8];
  endfunction

  function automatic logic [23:0] fade_pixel(input logic [23:0] c);
    return {fade_channel(c[23:16]), fade_channel(c[15:8]), fade_channel(c[7:0])};
  endfunction

endpackage

/* rtl/core/lres_ctrl.sv */
// Mode sequencer, effect timers and configuration registers.
// Produces one pixel operation, brightness and mode per word; uses lres_pkg.
module lres_ctrl #(
  parameter int PIXELS = lres_pkg::DEFAULT_PIXELS,
  localparam int PW = $clog2(PIXELS)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [lres_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [15:0]                        cfg_data,
  input  logic                               fire,
  input  logic [31:0]                        now_ms,
  input  logic                               sensor_active,
  input  logic [1:0]                         command,
  output lres_pkg::pix_cmd_t                 pix_cmd,
  output logic [PW-1:0]                      pos_next,
  output logic [7:0]                         brightness_next,
  output lres_pkg::mode_t                    mode_next
);

  localparam int RAMP_SHIFT_HI = lres_pkg::RAMP_SHIFT + 7;

  logic [7:0]  breathe_min, breathe_max;
  logic [15:0] breathe_step_ms, trigger_hold_ms, warning_hold_ms;
  logic [15:0] success_half_ms, warning_half_ms;

  lres_pkg::mode_t mode;
  logic [31:0] mode_start, mode_start_next;
  logic [7:0]  level, level_next;
  logic        rising, rising_next;
  logic [31:0] breathe_last, breathe_last_next;
  logic [7:0]  brightness;
  logic [PW-1:0] pos;
  logic [31:0] marquee_last, marquee_last_next;
  logic [1:0]  flash_count, flash_count_next;
  logic        flash_on, flash_on_next;
  logic [31:0] flash_last, flash_last_next;
  logic        blink_on, blink_on_next;
  logic [31:0] blink_last, blink_last_next;

  lres_pkg::mode_t m1;
  logic        enter_trig, enter_succ, enter_warn, enter_idle, entered;
  logic [31:0] elapsed_mode;
  logic [11:0] ramp_x;
  logic [31:0] ramp_prod;
  logic [7:0]  interval;
  logic [7:0]  lvl_base;
  logic        rise_base;
  logic signed [9:0] b, min_s, max_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      breathe_min     <= lres_pkg::RST_BREATHE_MIN;
      breathe_max     <= lres_pkg::RST_BREATHE_MAX;
      breathe_step_ms <= lres_pkg::RST_BREATHE_STEP;
      trigger_hold_ms <= lres_pkg::RST_TRIGGER_HOLD;
      warning_hold_ms <= lres_pkg::RST_WARNING_HOLD;
      success_half_ms <= lres_pkg::RST_SUCCESS_HALF;
      warning_half_ms <= lres_pkg::RST_WARNING_HALF;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lres_pkg::CFG_BREATHE_MIN:  breathe_min     <= cfg_data[7:0];
        lres_pkg::CFG_BREATHE_MAX:  breathe_max     <= cfg_data[7:0];
        lres_pkg::CFG_BREATHE_STEP: breathe_step_ms <= cfg_data;
        lres_pkg::CFG_TRIGGER_HOLD: trigger_hold_ms <= cfg_data;
        lres_pkg::CFG_WARNING_HOLD: warning_hold_ms <= cfg_data;
        lres_pkg::CFG_SUCCESS_HALF: success_half_ms <= cfg_data;
        lres_pkg::CFG_WARNING_HALF: warning_half_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= lres_pkg::MODE_IDLE;
      mode_start   <= '0;
      level        <= lres_pkg::RST_BREATHE_LVL;
      rising       <= 1'b1;
      breathe_last <= '0;
      brightness   <= lres_pkg::RST_BRIGHTNESS;
      pos          <= '0;
      marquee_last <= '0;
      flash_count  <= '0;
      flash_on     <= 1'b0;
      flash_last   <= '0;
      blink_on     <= 1'b0;
      blink_last   <= '0;
    end else if (fire) begin
      mode         <= mode_next;
      mode_start   <= mode_start_next;
      level        <= level_next;
      rising       <= rising_next;
      breathe_last <= breathe_last_next;
      brightness   <= brightness_next;
      pos          <= pos_next;
      marquee_last <= marquee_last_next;
      flash_count  <= flash_count_next;
      flash_on     <= flash_on_next;
      flash_last   <= flash_last_next;
      blink_on     <= blink_on_next;
      blink_last   <= blink_last_next;
    end
  end

  always_comb begin
    elapsed_mode = now_ms - mode_start;
    ramp_x    = (elapsed_mode > 32'(lres_pkg::RAMP_SPAN)) ? lres_pkg::RAMP_SPAN
                                                         : elapsed_mode[11:0];
    ramp_prod = 32'(ramp_x) * lres_pkg::RAMP_RECIP;
    interval  = lres_pkg::RAMP_START - ramp_prod[RAMP_SHIFT_HI:lres_pkg::RAMP_SHIFT];
  end

  always_comb begin
    m1         = mode;
    enter_trig = 1'b0;
    enter_succ = 1'b0;
    enter_warn = 1'b0;
    enter_idle = 1'b0;
    unique case (mode)
      lres_pkg::MODE_IDLE: begin
        if (sensor_active) begin
          m1         = lres_pkg::MODE_TRIG;
          enter_trig = 1'b1;
        end
        if (command == lres_pkg::CMD_WARN) begin
          m1         = lres_pkg::MODE_WARN;
          enter_warn = 1'b1;
        end
      end
      lres_pkg::MODE_TRIG: begin
        if (elapsed_mode > 32'(trigger_hold_ms)) begin
          m1         = lres_pkg::MODE_SUCC;
          enter_succ = 1'b1;
        end
        if (command == lres_pkg::CMD_FAIL) begin
          m1         = lres_pkg::MODE_WARN;
          enter_warn = 1'b1;
        end
      end
      lres_pkg::MODE_WARN: begin
        if (elapsed_mode > 32'(warning_hold_ms)) begin
          m1         = lres_pkg::MODE_IDLE;
          enter_idle = 1'b1;
        end
      end
      default: ;
    endcase
    entered = enter_trig | enter_succ | enter_warn | enter_idle;
  end

  always_comb begin
    mode_next         = m1;
    mode_start_next   = entered ? now_ms : mode_start;
    lvl_base          = enter_idle ? breathe_min : level;
    rise_base         = enter_idle | rising;
    level_next        = lvl_base;
    rising_next       = rise_base;
    breathe_last_next = breathe_last;
    brightness_next   = brightness;
    pos_next          = enter_trig ? '0 : pos;
    marquee_last_next = enter_trig ? now_ms : marquee_last;
    flash_count_next  = enter_succ ? 2'd0 : flash_count;
    flash_on_next     = enter_succ ? 1'b0 : flash_on;
    flash_last_next   = enter_succ ? now_ms : flash_last;
    blink_on_next     = enter_warn ? 1'b0 : blink_on;
    blink_last_next   = enter_warn ? now_ms : blink_last;
    pix_cmd.op        = enter_succ ? lres_pkg::PIX_FILL : lres_pkg::PIX_HOLD;
    pix_cmd.colour    = lres_pkg::COL_BLACK;
    min_s             = signed'({2'b00, breathe_min});
    max_s             = signed'({2'b00, breathe_max});
    b                 = signed'({2'b00, lvl_base}) + (rise_base ? 10'sd1 : -10'sd1);

    unique case (m1)
      lres_pkg::MODE_IDLE: begin
        if ((now_ms - breathe_last) >= 32'(breathe_step_ms)) begin
          breathe_last_next = now_ms;
          if (b <= min_s || b >= max_s) rising_next = !rise_base;
          if (b < min_s) b = min_s;
          if (b > max_s) b = max_s;
          level_next      = b[7:0];
          brightness_next = b[7:0];
          pix_cmd.op      = lres_pkg::PIX_FILL;
          pix_cmd.colour  = lres_pkg::COL_IDLE;
        end
      end
      lres_pkg::MODE_TRIG: begin
        if (!entered && (now_ms - marquee_last) > 32'(interval)) begin
          marquee_last_next = now_ms;
          pos_next          = (pos == PW'(PIXELS - 1)) ? '0 : pos + 1'b1;
          brightness_next   = lres_pkg::TRIG_BRIGHT;
          pix_cmd.op        = lres_pkg::PIX_MARQUEE;
          pix_cmd.colour    = lres_pkg::COL_TRIG;
        end
      end
      lres_pkg::MODE_SUCC: begin
        if (!entered && (now_ms - flash_last) > 32'(success_half_ms)) begin
          flash_last_next = now_ms;
          flash_on_next   = !flash_on;
          pix_cmd.op      = lres_pkg::PIX_FILL;
          if (!flash_on) begin
            brightness_next = lres_pkg::FLASH_BRIGHT;
            pix_cmd.colour  = lres_pkg::COL_SUCC;
            if (flash_count < 2'd3) flash_count_next = flash_count + 2'd1;
          end else if (flash_count >= 2'd2) begin
            mode_next       = lres_pkg::MODE_IDLE;
            mode_start_next = now_ms;
            level_next      = breathe_min;
            rising_next     = 1'b1;
          end
        end
      end
      lres_pkg::MODE_WARN: begin
        if (!entered && (now_ms - blink_last) > 32'(warning_half_ms)) begin
          blink_last_next = now_ms;
          blink_on_next   = !blink_on;
          brightness_next = lres_pkg::FLASH_BRIGHT;
          pix_cmd.op      = lres_pkg::PIX_ALTERNATE;
          pix_cmd.colour  = blink_on ? lres_pkg::COL_BLACK : lres_pkg::COL_WARN;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/lres_pixels.sv */
// Pixel store: one colour register per LED, each updated in parallel by
// the pass's pixel operation. Uses lres_pkg for operation codes and fade.
module lres_pixels #(
  parameter int PIXELS = lres_pkg::DEFAULT_PIXELS,
  localparam int PW = $clog2(PIXELS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  lres_pkg::pix_cmd_t pix_cmd,
  input  logic [PW-1:0]      pos_next,
  output logic [23:0]        pixel_next [PIXELS]
);

  logic [23:0] store [PIXELS];

  for (genvar i = 0; i < PIXELS; i++) begin : g_cell
    always_comb begin
      case (pix_cmd.op)
        lres_pkg::PIX_FILL:    pixel_next[i] = pix_cmd.colour;
        lres_pkg::PIX_MARQUEE: pixel_next[i] = (pos_next == PW'(i)) ? pix_cmd.colour
                                               : lres_pkg::fade_pixel(store[i]);
        lres_pkg::PIX_ALTERNATE: pixel_next[i] = (i % 2 == 0) ? pix_cmd.colour
                                                 : lres_pkg::COL_BLACK;
        default:               pixel_next[i] = store[i];
      endcase
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        store[i] <= lres_pkg::COL_BLACK;
      end else if (fire) begin
        store[i] <= pixel_next[i];
      end
    end
  end

endmodule

/* rtl/core/lres_emit.sv */
// Frame emitter: snapshot of one frame in a shift line, sent one pixel per
// output word. Uses lres_pkg for the mode type.
module lres_emit #(
  parameter int PIXELS = lres_pkg::DEFAULT_PIXELS,
  localparam int CW = $clog2(PIXELS)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic [23:0]     frame_in [PIXELS],
  input  logic [7:0]      brightness_in,
  input  lres_pkg::mode_t mode_in,
  output logic            load_ok,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [2:0]      pixel_index,
  output logic [7:0]      red,
  output logic [7:0]      green,
  output logic [7:0]      blue,
  output logic [7:0]      global_brightness,
  output logic [1:0]      mode,
  output logic            last_pixel
);

  logic [23:0]     frame [PIXELS];
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [7:0]      brightness;
  lres_pkg::mode_t frame_mode;
  logic            take;
  logic            last;

  assign last    = (cnt == CW'(PIXELS - 1));
  assign take    = busy && !out_stall;
  assign load_ok = !busy || (take && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (take) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame      <= frame_in;
      brightness <= brightness_in;
      frame_mode <= mode_in;
    end else if (take) begin
      for (int j = 0; j < PIXELS - 1; j++) frame[j] <= frame[j + 1];
    end
  end

  assign out_valid         = busy;
  assign pixel_index       = 3'(cnt);
  assign red               = frame[0][23:16];
  assign green             = frame[0][15:8];
  assign blue              = frame[0][7:0];
  assign global_brightness = brightness;
  assign mode              = frame_mode;
  assign last_pixel        = last;

endmodule

/* rtl/core/led_ring_effect_sequencer_unit.sv */
// Top level of the LED ring effect sequencer: input register, sequencer,
// pixel store and frame emitter. Uses lres_pkg, lres_ctrl, lres_pixels, lres_emit.
//
// Each input word (time, sensor level, command) produces one frame of PIXELS
// output words, one per LED in index order, the last flagged by last_pixel.
// A word waits in the input register, the mode and effect state is updated
// when the emitter can take a new frame, and the frame is then sent at one
// pixel per cycle while out_stall is low; the single pixel output port sets
// that rate. The next word is taken while the current frame drains, and frames
// follow each other without a gap. Reset has no clearing pass. Configuration
// writes are always ready and must be made while the block is idle.
module led_ring_effect_sequencer_unit #(
  parameter int PIXELS = lres_pkg::DEFAULT_PIXELS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lres_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                      cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [31:0]                      now_ms,
  input  logic                             sensor_active,
  input  logic [1:0]                       command,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       pixel_index,
  output logic [7:0]                       red,
  output logic [7:0]                       green,
  output logic [7:0]                       blue,
  output logic [7:0]                       global_brightness,
  output logic [1:0]                       mode,
  output logic                             last_pixel
);

  localparam int PW = $clog2(PIXELS);

  logic        in_full;
  logic [31:0] now_q;
  logic        sensor_q;
  logic [1:0]  command_q;
  logic        load_ok;
  logic        fire;
  logic        accept;

  lres_pkg::pix_cmd_t pix_cmd;
  logic [PW-1:0]      pos_next;
  logic [7:0]         brightness_next;
  lres_pkg::mode_t    mode_next;
  logic [23:0]        pixel_next [PIXELS];

  assign cfg_ready = 1'b1;
  assign fire      = in_full && load_ok;
  assign in_stall  = in_full && !load_ok;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_q     <= now_ms;
      sensor_q  <= sensor_active;
      command_q <= command;
    end
  end

  lres_ctrl #(.PIXELS(PIXELS)) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fire            (fire),
    .now_ms          (now_q),
    .sensor_active   (sensor_q),
    .command         (command_q),
    .pix_cmd         (pix_cmd),
    .pos_next        (pos_next),
    .brightness_next (brightness_next),
    .mode_next       (mode_next)
  );

  lres_pixels #(.PIXELS(PIXELS)) u_pixels (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .pix_cmd    (pix_cmd),
    .pos_next   (pos_next),
    .pixel_next (pixel_next)
  );

  lres_emit #(.PIXELS(PIXELS)) u_emit (
    .clk               (clk),
    .rst               (rst),
    .load              (fire),
    .frame_in          (pixel_next),
    .brightness_in     (brightness_next),
    .mode_in           (mode_next),
    .load_ok           (load_ok),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .pixel_index       (pixel_index),
    .red               (red),
    .green             (green),
    .blue              (blue),
    .global_brightness (global_brightness),
    .mode              (mode),
    .last_pixel        (last_pixel)
  );

endmodule
